[hdl/cue_pkg.sv]
// Shared types and constants for the console UART with echo.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package cue_pkg;

   // Item commands.
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_CHAR  = 2'd2;
   localparam logic [1:0] CMD_DRAIN = 2'd3;

   // Register offsets.
   localparam logic [7:0] ADDR_STATUS  = 8'd0;
   localparam logic [7:0] ADDR_DATA    = 8'd1;
   localparam logic [7:0] ADDR_CONTROL = 8'd2;
   localparam logic [7:0] ADDR_TX      = 8'd3;
   localparam logic [7:0] ADDR_VECTOR  = 8'd8;

   // Access sizes in bytes.
   localparam logic [3:0] SIZE_BYTE   = 4'd1;
   localparam logic [3:0] SIZE_VECTOR = 4'd8;

   // Control register bits.
   localparam int CTRL_ECHO_ALL = 7;
   localparam int CTRL_ECHO_TAB = 6;
   localparam int CTRL_ECHO_NL  = 5;
   localparam int CTRL_DESTR_BS = 4;
   localparam int CTRL_LOCKED   = 3;
   localparam int CTRL_IRQ_NL   = 2;
   localparam int CTRL_IRQ_ESC  = 1;
   localparam int CTRL_IRQ_ANY  = 0;

   localparam logic [7:0] CTRL_RESET = 8'hF0;

   // Characters.
   localparam logic [7:0] CH_XON  = 8'h11;
   localparam logic [7:0] CH_XOFF = 8'h13;
   localparam logic [7:0] CH_BELL = 8'h07;
   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_DEL  = 8'h7F;
   localparam logic [7:0] CH_BS   = 8'h08;
   localparam logic [7:0] CH_NL   = 8'h0A;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_SP   = 8'h20;

   // Entries in the queue between the front and the back.
   localparam int PLAN_DEPTH = 2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  bus_addr;
      logic [3:0]  bus_size;
      logic [63:0] write_data;
      logic [7:0]  rx_char;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        bus_error;
      logic        irq;
      logic [63:0] irq_vector;
      logic        term_valid;
      logic [7:0]  term_char;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        last;
   } rsp_type;

   // Everything one item produces; the back expands it into result words.
   typedef struct packed {
      logic [63:0]     read_data;
      logic            bus_error;
      logic            irq;
      logic [63:0]     irq_vector;
      logic            tx_valid;
      logic [7:0]      tx_byte;
      logic [2:0]      term_count;
      logic [3:0][7:0] term_chars;
   } plan_type;

endpackage

[hdl/cue_front.sv]
// Front end of the console: accepts request words, updates registers and both FIFOs,
// and hands one plan per item to the plan queue. Depends on cue_pkg.
`timescale 1ns / 1ps

module cue_front #(
   parameter int RX_DEPTH = 16,
   parameter int TX_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  cue_pkg::req_type  req_data,
   output logic              plan_valid,
   input  logic              plan_full,
   output cue_pkg::plan_type plan_data
);
   import cue_pkg::*;

   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int RX_CW = $clog2(RX_DEPTH + 1);
   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int TX_CW = $clog2(TX_DEPTH + 1);
   localparam logic [RX_CW-1:0] RX_FULL_CNT = RX_CW'(RX_DEPTH);
   localparam logic [RX_CW-1:0] RX_ALMOST   = RX_CW'(RX_DEPTH - 1);
   localparam logic [TX_CW-1:0] TX_FULL_CNT = TX_CW'(TX_DEPTH);
   localparam logic [RX_AW-1:0] RX_LAST_PTR = RX_AW'(RX_DEPTH - 1);
   localparam logic [TX_AW-1:0] TX_LAST_PTR = TX_AW'(TX_DEPTH - 1);

   logic [7:0]       rx_mem [RX_DEPTH];
   logic [7:0]       tx_mem [TX_DEPTH];

   logic [7:0]       control_ff, control_in;
   logic [63:0]      vector_ff, vector_in;
   logic [RX_AW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [RX_CW-1:0] rx_count_ff, rx_count_in;
   logic [TX_AW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [TX_CW-1:0] tx_count_ff, tx_count_in;
   logic [7:0]       rx_rd_ff, tx_rd_ff;

   logic             s2_valid_ff, s2_valid_in;
   plan_type         s2_plan_ff;
   logic             s2_rx_pop_ff, s2_tx_pop_ff;

   logic             accept;
   logic             rx_push, rx_pop, tx_push, tx_pop;
   logic             ctrl_wr, vec_wr;
   logic [7:0]       rx_char_eff;
   plan_type         plan_new;

   assign req_full = s2_valid_ff && plan_full;
   assign accept   = req_push && !req_full;

   // Decode one item into its state changes and its plan.
   always_comb begin
      logic [7:0]      c;
      logic [7:0]      cb;
      logic            rx_nonempty, rx_is_full, tx_is_full, fills;
      logic            sz_byte, sz_vec;
      logic [1:0]      ec;
      logic [2:0][7:0] e;

      c           = (req_data.rx_char == CH_DEL) ? CH_BS : req_data.rx_char;
      cb          = control_ff;
      rx_nonempty = (rx_count_ff != '0);
      rx_is_full  = (rx_count_ff == RX_FULL_CNT);
      tx_is_full  = (tx_count_ff == TX_FULL_CNT);
      fills       = (rx_count_ff == RX_ALMOST);
      sz_byte     = (req_data.bus_size == SIZE_BYTE);
      sz_vec      = (req_data.bus_size == SIZE_VECTOR);
      ec          = 2'd0;
      e           = '0;

      rx_char_eff = c;
      rx_push     = 1'b0;
      rx_pop      = 1'b0;
      tx_push     = 1'b0;
      tx_pop      = 1'b0;
      ctrl_wr     = 1'b0;
      vec_wr      = 1'b0;
      plan_new    = '0;

      // Echo characters for a received character.
      if (c != CH_NL && c != CH_TAB && c != CH_ESC && cb[CTRL_ECHO_ALL]) begin
         if (c == CH_BS) begin
            if (!cb[CTRL_LOCKED]) begin
               e[0] = CH_BS;
               ec   = 2'd1;
               if (cb[CTRL_DESTR_BS]) begin
                  e[1] = CH_SP;
                  e[2] = CH_BS;
                  ec   = 2'd3;
               end
            end
         end else begin
            e[0] = c;
            ec   = 2'd1;
         end
      end else if (c == CH_NL && cb[CTRL_ECHO_NL]) begin
         e[0] = c;
         ec   = 2'd1;
      end else if (c == CH_TAB && cb[CTRL_ECHO_TAB]) begin
         e[0] = c;
         ec   = 2'd1;
      end

      unique case (req_data.cmd)
         CMD_READ: begin
            if (req_data.bus_addr == ADDR_STATUS && sz_byte) begin
               plan_new.read_data = {61'd0, rx_is_full, !tx_is_full, rx_nonempty};
            end else if (req_data.bus_addr == ADDR_DATA && sz_byte) begin
               if (rx_nonempty) begin
                  rx_pop = 1'b1;
                  if (rx_is_full) begin
                     plan_new.term_count    = 3'd1;
                     plan_new.term_chars[0] = CH_XON;
                  end
               end
            end else if (req_data.bus_addr == ADDR_CONTROL && sz_byte) begin
               plan_new.read_data = {56'd0, control_ff};
            end else if (req_data.bus_addr == ADDR_VECTOR && sz_vec) begin
               plan_new.read_data = vector_ff;
            end else begin
               plan_new.bus_error = 1'b1;
            end
         end
         CMD_WRITE: begin
            if (req_data.bus_addr == ADDR_CONTROL && sz_byte) begin
               ctrl_wr = 1'b1;
            end else if (req_data.bus_addr == ADDR_TX && sz_byte) begin
               tx_push = !tx_is_full;
            end else if (req_data.bus_addr == ADDR_VECTOR && sz_vec) begin
               vec_wr = 1'b1;
            end else begin
               plan_new.bus_error = 1'b1;
            end
         end
         CMD_CHAR: begin
            if (rx_is_full) begin
               plan_new.term_count    = 3'd1;
               plan_new.term_chars[0] = CH_BELL;
            end else begin
               rx_push = 1'b1;
               if ((c == CH_NL && cb[CTRL_IRQ_NL]) || (c == CH_ESC && cb[CTRL_IRQ_ESC]) ||
                   cb[CTRL_IRQ_ANY] || fills) begin
                  plan_new.irq        = 1'b1;
                  plan_new.irq_vector = vector_ff;
               end
               if (fills) begin
                  plan_new.term_chars = {e[2], e[1], e[0], CH_XOFF};
                  plan_new.term_count = {1'b0, ec} + 3'd1;
               end else begin
                  plan_new.term_chars = {8'd0, e[2], e[1], e[0]};
                  plan_new.term_count = {1'b0, ec};
               end
            end
         end
         CMD_DRAIN: begin
            if (tx_count_ff != '0) begin
               tx_pop            = 1'b1;
               plan_new.tx_valid = 1'b1;
            end
         end
         default: begin
            plan_new.bus_error = 1'b1;
         end
      endcase
   end

   // Next state of registers and FIFO pointers.
   always_comb begin
      control_in  = control_ff;
      vector_in   = vector_ff;
      rx_head_in  = rx_head_ff;
      rx_tail_in  = rx_tail_ff;
      rx_count_in = rx_count_ff;
      tx_head_in  = tx_head_ff;
      tx_tail_in  = tx_tail_ff;
      tx_count_in = tx_count_ff;
      if (accept) begin
         if (ctrl_wr) control_in = req_data.write_data[7:0];
         if (vec_wr)  vector_in  = req_data.write_data;
         if (rx_push) begin
            rx_head_in  = (rx_head_ff == RX_LAST_PTR) ? '0 : rx_head_ff + 1'b1;
            rx_count_in = rx_count_ff + 1'b1;
         end
         if (rx_pop) begin
            rx_tail_in  = (rx_tail_ff == RX_LAST_PTR) ? '0 : rx_tail_ff + 1'b1;
            rx_count_in = rx_count_ff - 1'b1;
         end
         if (tx_push) begin
            tx_head_in  = (tx_head_ff == TX_LAST_PTR) ? '0 : tx_head_ff + 1'b1;
            tx_count_in = tx_count_ff + 1'b1;
         end
         if (tx_pop) begin
            tx_tail_in  = (tx_tail_ff == TX_LAST_PTR) ? '0 : tx_tail_ff + 1'b1;
            tx_count_in = tx_count_ff - 1'b1;
         end
      end
   end

   // The plan stage empties into the queue whenever the queue has room.
   always_comb begin
      if (accept) begin
         s2_valid_in = 1'b1;
      end else if (!plan_full) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff  <= CTRL_RESET;
         vector_ff   <= '0;
         rx_head_ff  <= '0;
         rx_tail_ff  <= '0;
         rx_count_ff <= '0;
         tx_head_ff  <= '0;
         tx_tail_ff  <= '0;
         tx_count_ff <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         control_ff  <= control_in;
         vector_ff   <= vector_in;
         rx_head_ff  <= rx_head_in;
         rx_tail_ff  <= rx_tail_in;
         rx_count_ff <= rx_count_in;
         tx_head_ff  <= tx_head_in;
         tx_tail_ff  <= tx_tail_in;
         tx_count_ff <= tx_count_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Plan stage payload, loaded with each accepted item.
   always_ff @(posedge clock) begin
      if (accept) begin
         s2_plan_ff   <= plan_new;
         s2_rx_pop_ff <= rx_pop;
         s2_tx_pop_ff <= tx_pop;
      end
   end

   // Receive FIFO storage; the popped byte is registered beside the plan stage.
   always_ff @(posedge clock) begin
      if (accept && rx_push) begin
         rx_mem[rx_head_ff] <= rx_char_eff;
      end
      if (accept && rx_pop) begin
         rx_rd_ff <= rx_mem[rx_tail_ff];
      end
   end

   // Transmit FIFO storage.
   always_ff @(posedge clock) begin
      if (accept && tx_push) begin
         tx_mem[tx_head_ff] <= req_data.write_data[7:0];
      end
      if (accept && tx_pop) begin
         tx_rd_ff <= tx_mem[tx_tail_ff];
      end
   end

   // Merge the memory read data into the plan on its way to the queue.
   always_comb begin
      plan_data = s2_plan_ff;
      if (s2_rx_pop_ff) plan_data.read_data = {56'd0, rx_rd_ff};
      if (s2_tx_pop_ff) plan_data.tx_byte   = tx_rd_ff;
   end

   assign plan_valid = s2_valid_ff;

endmodule

[hdl/cue_queue.sv]
// Short queue of plans between the front and the back of the console.
// Depends on cue_pkg for the plan type and the queue depth.
`timescale 1ns / 1ps

module cue_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_full,
   input  cue_pkg::plan_type in_data,
   output logic              out_valid,
   input  logic              out_pop,
   output cue_pkg::plan_type out_data
);
   import cue_pkg::*;

   localparam int AW = $clog2(PLAN_DEPTH);
   localparam int CW = $clog2(PLAN_DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(PLAN_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(PLAN_DEPTH);

   plan_type        entry_ff [PLAN_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign in_full   = (count_ff == FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign do_push   = in_valid && !in_full;
   assign do_pop    = out_pop && out_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= in_data;
   end

endmodule

[hdl/cue_back.sv]
// Back end of the console: expands each plan into one to four result words
// and holds the oldest one in the output register. Depends on cue_pkg.
`timescale 1ns / 1ps

module cue_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              plan_valid,
   output logic              plan_pop,
   input  cue_pkg::plan_type plan_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output cue_pkg::rsp_type  rsp_data
);
   import cue_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   rsp_type    word;
   logic [1:0] last_idx;
   logic       load;
   logic       first;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign load      = plan_valid && (!out_valid_ff || rsp_pop);
   assign first     = (idx_ff == 2'd0);
   assign last_idx  = (plan_data.term_count == 3'd0) ? 2'd0 : 2'(plan_data.term_count - 3'd1);
   assign plan_pop  = load && (idx_ff == last_idx);

   // Build the result word at the current position within the plan.
   always_comb begin
      word            = '0;
      word.term_valid = ({1'b0, idx_ff} < plan_data.term_count);
      word.term_char  = word.term_valid ? plan_data.term_chars[idx_ff] : 8'd0;
      word.last       = (idx_ff == last_idx);
      if (first) begin
         word.read_data  = plan_data.read_data;
         word.bus_error  = plan_data.bus_error;
         word.irq        = plan_data.irq;
         word.irq_vector = plan_data.irq_vector;
         word.tx_valid   = plan_data.tx_valid;
         word.tx_byte    = plan_data.tx_byte;
      end
   end

   // Position within the plan and output register occupancy.
   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         idx_in       = plan_pop ? 2'd0 : idx_ff + 2'd1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) out_ff <= word;
   end

endmodule

[hdl/console_uart_with_echo_unit.sv]
// Console UART with receive and transmit FIFOs and terminal echo. The request side
// takes one word per cycle while req_full is low: a bus read, a bus write, a
// received character or a transmit drain tick. An accepted word passes the plan
// stage, the plan queue and the output register before it shows on the result
// ports. The result side delivers one word per cycle while words wait and rsp_pop
// is high; most items give one result, and a received character gives up to four
// (XOFF and three echo characters) that hold the result side while the two-entry
// plan queue keeps accepting. req_full rises only when that queue is full and the
// plan stage ahead of it is occupied. FIFO storage is one memory per direction,
// RX_DEPTH and TX_DEPTH bytes deep, with no clearing pass after reset.
// Depends on cue_pkg, cue_front, cue_queue and cue_back.
`timescale 1ns / 1ps

module console_uart_with_echo_unit #(
   parameter int RX_DEPTH = 16,
   parameter int TX_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  cue_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cue_pkg::rsp_type rsp_data
);
   import cue_pkg::*;

   logic     fe_valid, q_full;
   plan_type fe_plan;
   logic     q_valid, q_pop;
   plan_type q_plan;

   // Front end: decode, register and FIFO updates.
   cue_front #(
      .RX_DEPTH(RX_DEPTH),
      .TX_DEPTH(TX_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .plan_valid(fe_valid),
      .plan_full (q_full),
      .plan_data (fe_plan)
   );

   // Plan queue between the two halves.
   cue_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fe_valid),
      .in_full  (q_full),
      .in_data  (fe_plan),
      .out_valid(q_valid),
      .out_pop  (q_pop),
      .out_data (q_plan)
   );

   // Back end: result word expansion and output register.
   cue_back u_back (
      .clock     (clock),
      .reset     (reset),
      .plan_valid(q_valid),
      .plan_pop  (q_pop),
      .plan_data (q_plan),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/tb_console_uart_with_echo_unit.sv]
// Self-checking testbench for the console UART with echo: bus reads and writes, received
// characters and drain ticks go in, and every result word is checked against a predictor.
// Depends on cue_pkg and console_uart_with_echo_unit.
`timescale 1ns / 1ps

module tb_console_uart_with_echo_unit;
   import cue_pkg::*;

   localparam int RX_DEPTH       = 16;
   localparam int TX_DEPTH       = 16;
   localparam int DIRECTED_ITEMS = 27;
   localparam int RANDOM_ITEMS   = 410;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES  = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   // Stimulus and expected result words.
   req_type pending_req_words[$];
   rsp_type expected_rsp_words[$];
   int      total_items = 0;
   int      accepted_items = 0;
   int      failures = 0;
   int      cycle_count = 0;
   int      drv_gap = 0;
   int      drv_calm = 0;
   int      mon_stall = 0;
   int      mon_calm = 0;

   // Shadow of the console state.
   logic [7:0]  sh_rx_mem[RX_DEPTH];
   logic [7:0]  sh_tx_mem[TX_DEPTH];
   int          sh_rx_rd = 0;
   int          sh_rx_wr = 0;
   int          sh_rx_count = 0;
   int          sh_tx_rd = 0;
   int          sh_tx_wr = 0;
   int          sh_tx_count = 0;
   logic [7:0]  sh_ctrl = CTRL_RESET;
   logic [63:0] sh_vector = '0;

   console_uart_with_echo_unit #(
      .RX_DEPTH(RX_DEPTH),
      .TX_DEPTH(TX_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap length: mostly none or short, a few long, with calm stretches of no gaps at all.
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Bus access word; the character field carries noise.
   function automatic req_type make_bus(logic [1:0] cmd, logic [7:0] addr, logic [3:0] size,
                                        logic [63:0] wd);
      req_type r;
      r.cmd        = cmd;
      r.bus_addr   = addr;
      r.bus_size   = size;
      r.write_data = wd;
      r.rx_char    = 8'($urandom_range(0, 255));
      return r;
   endfunction

   // Received character or drain tick; the bus fields carry noise.
   function automatic req_type make_other(logic [1:0] cmd, logic [7:0] ch);
      req_type r;
      r.cmd        = cmd;
      r.bus_addr   = 8'($urandom_range(0, 255));
      r.bus_size   = 4'($urandom_range(0, 15));
      r.write_data = rand64();
      r.rx_char    = ch;
      return r;
   endfunction

   // Terminal characters, weighted toward the ones with special handling.
   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 11))
         0: return CH_NL;
         1: return CH_TAB;
         2: return CH_ESC;
         3: return CH_DEL;
         4: return CH_BS;
         5, 6: return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(8'h21, 8'h7E));
      endcase
   endfunction

   // Works out the result words of one accepted word and updates the shadow state.
   function automatic void predict_console_response(input req_type r);
      rsp_type    first;
      rsp_type    word;
      logic [7:0] chars[$];
      logic [7:0] c;
      logic       filled;
      int         n;
      first = '0;
      c = r.rx_char;
      case (r.cmd)
         CMD_READ: begin
            if (r.bus_addr == ADDR_STATUS && r.bus_size == SIZE_BYTE) begin
               first.read_data = {61'd0, sh_rx_count == RX_DEPTH, sh_tx_count < TX_DEPTH,
                                  sh_rx_count != 0};
            end else if (r.bus_addr == ADDR_DATA && r.bus_size == SIZE_BYTE) begin
               if (sh_rx_count != 0) begin
                  // Popping a full receive FIFO releases the terminal with XON.
                  if (sh_rx_count == RX_DEPTH) chars.push_back(CH_XON);
                  first.read_data = {56'd0, sh_rx_mem[sh_rx_rd]};
                  sh_rx_rd = (sh_rx_rd + 1) % RX_DEPTH;
                  sh_rx_count--;
               end
            end else if (r.bus_addr == ADDR_CONTROL && r.bus_size == SIZE_BYTE) begin
               first.read_data = {56'd0, sh_ctrl};
            end else if (r.bus_addr == ADDR_VECTOR && r.bus_size == SIZE_VECTOR) begin
               first.read_data = sh_vector;
            end else begin
               first.bus_error = 1'b1;
            end
         end
         CMD_WRITE: begin
            if (r.bus_addr == ADDR_CONTROL && r.bus_size == SIZE_BYTE) begin
               sh_ctrl = r.write_data[7:0];
            end else if (r.bus_addr == ADDR_TX && r.bus_size == SIZE_BYTE) begin
               if (sh_tx_count < TX_DEPTH) begin
                  sh_tx_mem[sh_tx_wr] = r.write_data[7:0];
                  sh_tx_wr = (sh_tx_wr + 1) % TX_DEPTH;
                  sh_tx_count++;
               end
            end else if (r.bus_addr == ADDR_VECTOR && r.bus_size == SIZE_VECTOR) begin
               sh_vector = r.write_data;
            end else begin
               first.bus_error = 1'b1;
            end
         end
         CMD_CHAR: begin
            if (c == CH_DEL) c = CH_BS;
            if (sh_rx_count >= RX_DEPTH) begin
               chars.push_back(CH_BELL);
            end else begin
               sh_rx_mem[sh_rx_wr] = c;
               sh_rx_wr = (sh_rx_wr + 1) % RX_DEPTH;
               sh_rx_count++;
               filled = (sh_rx_count == RX_DEPTH);
               if (filled) chars.push_back(CH_XOFF);
               if ((c == CH_NL && sh_ctrl[CTRL_IRQ_NL]) || (c == CH_ESC && sh_ctrl[CTRL_IRQ_ESC])
                   || sh_ctrl[CTRL_IRQ_ANY] || filled) begin
                  first.irq        = 1'b1;
                  first.irq_vector = sh_vector;
               end
               // Echo: newline and tab have their own bits, ESC is never echoed.
               if (c == CH_NL) begin
                  if (sh_ctrl[CTRL_ECHO_NL]) chars.push_back(c);
               end else if (c == CH_TAB) begin
                  if (sh_ctrl[CTRL_ECHO_TAB]) chars.push_back(c);
               end else if (c != CH_ESC && sh_ctrl[CTRL_ECHO_ALL]) begin
                  if (c == CH_BS) begin
                     if (!sh_ctrl[CTRL_LOCKED]) begin
                        chars.push_back(CH_BS);
                        if (sh_ctrl[CTRL_DESTR_BS]) begin
                           chars.push_back(CH_SP);
                           chars.push_back(CH_BS);
                        end
                     end
                  end else begin
                     chars.push_back(c);
                  end
               end
            end
         end
         default: begin
            if (sh_tx_count != 0) begin
               first.tx_valid = 1'b1;
               first.tx_byte  = sh_tx_mem[sh_tx_rd];
               sh_tx_rd = (sh_tx_rd + 1) % TX_DEPTH;
               sh_tx_count--;
            end
         end
      endcase
      // One word per terminal character, at least one word; flags ride on the first.
      n = (chars.size() == 0) ? 1 : chars.size();
      for (int i = 0; i < n; i++) begin
         word = (i == 0) ? first : '0;
         if (i < chars.size()) begin
            word.term_valid = 1'b1;
            word.term_char  = chars[i];
         end
         word.last = (i == n - 1);
         expected_rsp_words.push_back(word);
      end
   endfunction

   task automatic note_failure(input string what, input rsp_type exp, input rsp_type got);
      failures++;
      if (failures <= 10) begin
         $display("%0t: %s", $realtime, what);
         $display("   expected rd=%h err=%b irq=%b vec=%h term=%b/%h tx=%b/%h last=%b",
                  exp.read_data, exp.bus_error, exp.irq, exp.irq_vector, exp.term_valid,
                  exp.term_char, exp.tx_valid, exp.tx_byte, exp.last);
         $display("   actual   rd=%h err=%b irq=%b vec=%h term=%b/%h tx=%b/%h last=%b",
                  got.read_data, got.bus_error, got.irq, got.irq_vector, got.term_valid,
                  got.term_char, got.tx_valid, got.tx_byte, got.last);
      end
   endtask

   // Driver: presents pending words, holds while full, predicts each accepted word.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_console_response(req_data);
            accepted_items++;
         end
         if (req_push && req_full) begin
            // Word still waiting; keep it on the ports.
         end else if (drv_gap > 0) begin
            drv_gap--;
            req_push <= 1'b0;
         end else if (pending_req_words.size() != 0) begin
            req_data <= pending_req_words.pop_front();
            req_push <= 1'b1;
            drv_gap = pick_gap(drv_calm);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Monitor: pops with random stalls and checks each word against the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsp_words.size() == 0) begin
               note_failure("result word with nothing expected", '0, rsp_data);
            end else begin
               exp = expected_rsp_words.pop_front();
               if (rsp_data.read_data !== exp.read_data || rsp_data.bus_error !== exp.bus_error
                   || rsp_data.irq !== exp.irq || rsp_data.irq_vector !== exp.irq_vector
                   || rsp_data.term_valid !== exp.term_valid
                   || rsp_data.term_char !== exp.term_char
                   || rsp_data.tx_valid !== exp.tx_valid || rsp_data.tx_byte !== exp.tx_byte
                   || rsp_data.last !== exp.last) begin
                  note_failure("result word mismatch", exp, rsp_data);
               end
            end
            mon_stall = pick_gap(mon_calm);
         end
         if (mon_stall > 0) begin
            mon_stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_console_uart_with_echo_unit: FAIL");
         $finish;
      end
   end

   initial begin
      int n;
      int m;
      // Directed words: reset values, empty pops, bad accesses and each echo path.
      pending_req_words.push_back(make_bus(CMD_READ, ADDR_STATUS, SIZE_BYTE, rand64()));
      pending_req_words.push_back(make_bus(CMD_READ, ADDR_CONTROL, SIZE_BYTE, rand64()));
      pending_req_words.push_back(make_bus(CMD_READ, ADDR_VECTOR, SIZE_VECTOR, rand64()));
      pending_req_words.push_back(make_bus(CMD_READ, ADDR_DATA, SIZE_BYTE, rand64()));
      pending_req_words.push_back(make_other(CMD_DRAIN, 8'hFF));
      pending_req_words.push_back(make_bus(CMD_READ, ADDR_TX, SIZE_BYTE, rand64()));
      pending_req_words.push_back(make_bus(CMD_WRITE, ADDR_STATUS, SIZE_BYTE, '1));
      pending_req_words.push_back(make_bus(CMD_WRITE, ADDR_DATA, SIZE_BYTE, '1));
      pending_req_words.push_back(make_bus(CMD_READ, ADDR_CONTROL, SIZE_VECTOR, '0));
      pending_req_words.push_back(make_bus(CMD_WRITE, ADDR_VECTOR, SIZE_BYTE, '1));
      pending_req_words.push_back(make_bus(CMD_READ, 8'hFF, 4'hF, '1));
      pending_req_words.push_back(make_bus(CMD_WRITE, 8'h04, 4'h0, '1));
      pending_req_words.push_back(make_bus(CMD_WRITE, ADDR_VECTOR, SIZE_VECTOR, '1));
      pending_req_words.push_back(make_bus(CMD_READ, ADDR_VECTOR, SIZE_VECTOR, '0));
      pending_req_words.push_back(make_other(CMD_CHAR, 8'h41));
      pending_req_words.push_back(make_other(CMD_CHAR, CH_DEL));
      pending_req_words.push_back(make_other(CMD_CHAR, CH_TAB));
      pending_req_words.push_back(make_other(CMD_CHAR, CH_NL));
      pending_req_words.push_back(make_other(CMD_CHAR, CH_ESC));
      pending_req_words.push_back(make_bus(CMD_WRITE, ADDR_CONTROL, SIZE_BYTE, 64'hFF));
      pending_req_words.push_back(make_other(CMD_CHAR, CH_BS));
      pending_req_words.push_back(make_other(CMD_CHAR, 8'h00));
      pending_req_words.push_back(make_bus(CMD_WRITE, ADDR_CONTROL, SIZE_BYTE, 64'h06));
      pending_req_words.push_back(make_other(CMD_CHAR, CH_NL));
      pending_req_words.push_back(make_other(CMD_CHAR, CH_ESC));
      pending_req_words.push_back(make_bus(CMD_WRITE, ADDR_TX, SIZE_BYTE, 64'hA5));
      pending_req_words.push_back(make_other(CMD_DRAIN, 8'h00));

      // Random part: receive and transmit bursts that fill and drain the FIFOs,
      // register traffic, and some noise.
      while (pending_req_words.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               n = $urandom_range(1, 20);
               m = $urandom_range(0, 20);
               repeat (n) pending_req_words.push_back(make_other(CMD_CHAR, pick_char()));
               repeat (m) begin
                  if ($urandom_range(0, 4) == 0)
                     pending_req_words.push_back(make_bus(CMD_READ, ADDR_STATUS, SIZE_BYTE,
                                                          rand64()));
                  else
                     pending_req_words.push_back(make_bus(CMD_READ, ADDR_DATA, SIZE_BYTE,
                                                          rand64()));
               end
            end
            4, 5: begin
               n = $urandom_range(1, 20);
               m = $urandom_range(0, 20);
               repeat (n) pending_req_words.push_back(make_bus(CMD_WRITE, ADDR_TX, SIZE_BYTE,
                                                               rand64()));
               repeat (m) pending_req_words.push_back(make_other(CMD_DRAIN, pick_char()));
            end
            6: begin
               case ($urandom_range(0, 3))
                  0: n = 8'h00;
                  1: n = 8'hFF;
                  default: n = $urandom_range(0, 255);
               endcase
               pending_req_words.push_back(make_bus(CMD_WRITE, ADDR_CONTROL, SIZE_BYTE,
                                                    {56'(rand64()), 8'(n)}));
               pending_req_words.push_back(make_bus(CMD_READ, ADDR_CONTROL, SIZE_BYTE,
                                                    rand64()));
            end
            7: begin
               pending_req_words.push_back(make_bus(CMD_WRITE, ADDR_VECTOR, SIZE_VECTOR,
                                                    rand64()));
               pending_req_words.push_back(make_bus(CMD_READ, ADDR_VECTOR, SIZE_VECTOR,
                                                    rand64()));
            end
            default: begin
               repeat ($urandom_range(1, 4)) begin
                  req_type r;
                  r.cmd        = 2'($urandom_range(0, 3));
                  r.bus_addr   = $urandom_range(0, 1) ? 8'($urandom_range(0, 9))
                                                      : 8'($urandom_range(0, 255));
                  r.bus_size   = 4'($urandom_range(0, 15));
                  r.write_data = rand64();
                  r.rx_char    = 8'($urandom_range(0, 255));
                  pending_req_words.push_back(r);
               end
            end
         endcase
      end
      total_items = pending_req_words.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Drain: all words accepted, all results seen, then a short settle.
      while (accepted_items < total_items) @(negedge clock);
      while (expected_rsp_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (failures == 0 && expected_rsp_words.size() == 0) begin
         $display("tb_console_uart_with_echo_unit: PASS");
      end else begin
         $display("tb_console_uart_with_echo_unit: FAIL");
      end
      $finish;
   end

endmodule

[files.f]
hdl/cue_pkg.sv
hdl/cue_front.sv
hdl/cue_queue.sv
hdl/cue_back.sv
hdl/console_uart_with_echo_unit.sv
tb/tb_console_uart_with_echo_unit.sv
